### hw/rtl/ste_pkg.sv
// Shared types, codes and helpers for the symbol table engine.
// No dependencies; used by every module of the block.
package ste_pkg;

  localparam int DEPTH_DEF     = 32;
  localparam int KEY_CHARS_DEF = 8;

  localparam int ACT_W    = 2;
  localparam int KEY_W    = 64;
  localparam int VAL_W    = 32;
  localparam int STATUS_W = 3;
  localparam int LOC_W    = 6;

  localparam logic [ACT_W-1:0] ACT_CLEAR  = 2'd0;
  localparam logic [ACT_W-1:0] ACT_INSERT = 2'd1;
  localparam logic [ACT_W-1:0] ACT_MODIFY = 2'd2;
  localparam logic [ACT_W-1:0] ACT_SEARCH = 2'd3;

  localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd1;
  localparam logic [STATUS_W-1:0] ST_FULL      = 3'd2;
  localparam logic [STATUS_W-1:0] ST_DUP       = 3'd3;
  localparam logic [STATUS_W-1:0] ST_BAD       = 3'd4;

  localparam logic [7:0] CHAR_NUL   = 8'h00;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;

  typedef struct packed {
    logic [KEY_W-1:0] name;
    logic [VAL_W-1:0] value;
  } entry_t;

  function automatic logic name_bad(input logic [KEY_W-1:0] nm);
    logic [7:0] first;
    first = nm[KEY_W-1 -: 8];
    return (first == CHAR_NUL) || ((first >= CHAR_ZERO) && (first <= CHAR_NINE));
  endfunction

endpackage

### hw/rtl/ste_norm.sv
// Name normalizer: keeps the top KEY_CHARS bytes up to the first NUL.
// Depends on ste_pkg for the key width.
module ste_norm #(
  parameter int KEY_CHARS = ste_pkg::KEY_CHARS_DEF
) (
  input  logic [ste_pkg::KEY_W-1:0] raw,
  output logic [ste_pkg::KEY_W-1:0] norm
);

  always_comb begin
    logic       keep;
    logic [7:0] ch;
    keep = 1'b1;
    norm = '0;
    for (int b = 7; b >= 0; b--) begin
      ch = raw[8*b +: 8];
      if ((7 - b) >= KEY_CHARS) begin
        ch = 8'h00;
      end
      if (ch == ste_pkg::CHAR_NUL) begin
        keep = 1'b0;
      end
      norm[8*b +: 8] = keep ? ch : 8'h00;
    end
  end

endmodule

### hw/rtl/ste_mem.sv
// Entry store: one write port, one read port with registered read data.
// Depends on ste_pkg for the entry type.
module ste_mem #(
  parameter int DEPTH = ste_pkg::DEPTH_DEF,
  parameter int AW    = 5
) (
  input  logic                  clk,
  input  logic                  we,
  input  logic [AW-1:0]         waddr,
  input  ste_pkg::entry_t       wdata,
  input  logic [AW-1:0]         raddr,
  output ste_pkg::entry_t       rdata
);

  ste_pkg::entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

### hw/rtl/symbol_table_engine_core.sv
// Symbol table engine top level: sequencer, result register and entry store.
// Depends on ste_pkg, ste_norm and ste_mem.
//
// Input channel (in_valid/in_stall) carries action, key, new_key and value;
// output channel (out_valid/out_stall) carries status, location, found_value
// and entry_count, one result per transfer in.
// A transfer in is taken only while the sequencer is idle. Insert, modify and
// search scan the stored names in order, one read issued per cycle, with each
// compare in the cycle after its read. An item is accepted, scanned and
// committed; a scan stops at the first matching name. Clear, and an insert
// refused as full or for a bad name, go from accept straight to commit.
// The result lands in an output register; a new transfer in is taken while
// it waits. If the receiver stalls when the next result is ready, the
// sequencer holds that result and the store write until the register frees.
// Reset empties the table at once (internal entry count zero, no pending result);
// stored entries are never read before they are written.
module symbol_table_engine_core #(
  parameter int DEPTH     = ste_pkg::DEPTH_DEF,
  parameter int KEY_CHARS = ste_pkg::KEY_CHARS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [ste_pkg::ACT_W-1:0]          action,
  input  logic [ste_pkg::KEY_W-1:0]          key,
  input  logic [ste_pkg::KEY_W-1:0]          new_key,
  input  logic signed [ste_pkg::VAL_W-1:0]   value,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [ste_pkg::STATUS_W-1:0]       status,
  output logic [ste_pkg::LOC_W-1:0]          location,
  output logic signed [ste_pkg::VAL_W-1:0]   found_value,
  output logic [ste_pkg::LOC_W-1:0]          entry_count
);

  localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_SCAN   = 2'd1;
  localparam logic [1:0] S_FINISH = 2'd2;

  logic [1:0]                    state;
  logic [ste_pkg::ACT_W-1:0]     act_r;
  logic [ste_pkg::KEY_W-1:0]     key_r;
  logic [ste_pkg::KEY_W-1:0]     nkey_r;
  logic [ste_pkg::VAL_W-1:0]     val_r;
  logic [CW-1:0]                 used;
  logic [CW-1:0]                 scan_ptr;
  logic                          cmp_valid;
  logic [CW-1:0]                 cmp_ptr;
  logic [ste_pkg::STATUS_W-1:0]  res_status;
  logic [CW-1:0]                 res_loc;
  logic [ste_pkg::VAL_W-1:0]     res_val;
  logic [CW-1:0]                 res_count;
  logic                          wr_pend;
  logic [IW-1:0]                 wr_addr;

  logic [ste_pkg::KEY_W-1:0]     key_n;
  logic [ste_pkg::KEY_W-1:0]     nkey_n;
  ste_pkg::entry_t               rd_entry;
  ste_pkg::entry_t               wr_entry;
  logic                          acc;
  logic                          issue;
  logic                          hit;
  logic                          miss;
  logic                          commit;
  logic                          mem_we;
  logic [CW-1:0]                 cmp_loc;

  ste_norm #(.KEY_CHARS(KEY_CHARS)) u_norm_key (
    .raw  (key),
    .norm (key_n)
  );

  ste_norm #(.KEY_CHARS(KEY_CHARS)) u_norm_nkey (
    .raw  (new_key),
    .norm (nkey_n)
  );

  assign wr_entry.name  = (act_r == ste_pkg::ACT_MODIFY) ? nkey_r : key_r;
  assign wr_entry.value = val_r;

  ste_mem #(.DEPTH(DEPTH), .AW(IW)) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (wr_addr),
    .wdata (wr_entry),
    .raddr (scan_ptr[IW-1:0]),
    .rdata (rd_entry)
  );

  assign in_stall = (state != S_IDLE);
  assign acc      = in_valid && !in_stall;
  assign issue    = (state == S_SCAN) && (scan_ptr < used);
  assign cmp_loc  = CW'(cmp_ptr + 1'b1);
  assign hit      = (state == S_SCAN) && cmp_valid && (rd_entry.name == key_r);
  assign miss     = (state == S_SCAN) && !hit &&
                    ((used == '0) || (cmp_valid && (cmp_loc == used)));
  assign commit   = (state == S_FINISH) && (!out_valid || !out_stall);
  assign mem_we   = commit && wr_pend;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      used      <= '0;
      out_valid <= 1'b0;
      cmp_valid <= 1'b0;
    end else begin
      if (commit) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (acc) begin
            act_r     <= action;
            key_r     <= key_n;
            nkey_r    <= nkey_n;
            val_r     <= value;
            scan_ptr  <= '0;
            cmp_valid <= 1'b0;
            res_loc   <= '0;
            res_val   <= '0;
            wr_pend   <= 1'b0;
            if (action == ste_pkg::ACT_CLEAR) begin
              res_status <= ste_pkg::ST_OK;
              res_count  <= '0;
              state      <= S_FINISH;
            end else if ((action == ste_pkg::ACT_INSERT) && (used >= CW'(DEPTH))) begin
              res_status <= ste_pkg::ST_FULL;
              res_count  <= used;
              state      <= S_FINISH;
            end else if ((action == ste_pkg::ACT_INSERT) && ste_pkg::name_bad(key_n)) begin
              res_status <= ste_pkg::ST_BAD;
              res_count  <= used;
              state      <= S_FINISH;
            end else begin
              res_status <= ste_pkg::ST_OK;
              res_count  <= used;
              state      <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          cmp_valid <= issue;
          cmp_ptr   <= scan_ptr;
          if (issue) begin
            scan_ptr <= CW'(scan_ptr + 1'b1);
          end
          if (hit) begin
            state <= S_FINISH;
            case (act_r)
              ste_pkg::ACT_INSERT: res_status <= ste_pkg::ST_DUP;
              ste_pkg::ACT_MODIFY: begin
                if (ste_pkg::name_bad(nkey_r)) begin
                  res_status <= ste_pkg::ST_BAD;
                end else begin
                  res_loc <= cmp_loc;
                  res_val <= val_r;
                  wr_pend <= 1'b1;
                  wr_addr <= cmp_ptr[IW-1:0];
                end
              end
              default: begin
                res_loc <= cmp_loc;
                res_val <= rd_entry.value;
              end
            endcase
          end else if (miss) begin
            state <= S_FINISH;
            if (act_r == ste_pkg::ACT_INSERT) begin
              res_loc   <= CW'(used + 1'b1);
              res_val   <= val_r;
              res_count <= CW'(used + 1'b1);
              wr_pend   <= 1'b1;
              wr_addr   <= used[IW-1:0];
            end else begin
              res_status <= ste_pkg::ST_NOT_FOUND;
            end
          end
        end
        S_FINISH: begin
          if (commit) begin
            status      <= res_status;
            location    <= ste_pkg::LOC_W'(res_loc);
            found_value <= res_val;
            entry_count <= ste_pkg::LOC_W'(res_count);
            used        <= res_count;
            state       <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_used_bound: assert property (@(posedge clk) disable iff (rst)
    used <= CW'(DEPTH))
    else $error("entry count beyond capacity");

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    acc |=> state != S_IDLE)
    else $error("sequencer stayed idle after a transfer in");

  a_write_on_commit: assert property (@(posedge clk) disable iff (rst)
    mem_we |-> (state == S_FINISH) && (res_status == ste_pkg::ST_OK))
    else $error("store write outside a successful commit");

  a_result_from_finish: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == S_FINISH)
    else $error("result loaded outside commit");

  a_error_zero_fields: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (status != ste_pkg::ST_OK)) |-> (location == '0) && (found_value == '0))
    else $error("error result with nonzero location or value");

endmodule
